// ===== rtl/core/lssp_pkg.sv =====
// Shared types and constants for the longest subarray sum block.
`timescale 1ns / 1ps

package lssp_pkg;

  localparam int VALUE_W  = 16;
  localparam int TARGET_W = 24;
  localparam int SUM_W    = 25;
  localparam int KEY_W    = 26;
  localparam int BEST_W   = 9;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } req_t;

  typedef struct packed {
    logic [BEST_W-1:0] best_length;
    logic              last_res;
    logic              overflow;
  } res_t;

  typedef struct packed {
    logic cmp_en;
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== rtl/core/lssp_cell.sv =====
// One table cell: holds a stored prefix and its first index, compares and shifts.
`timescale 1ns / 1ps

module lssp_cell #(
  parameter int IDX_W = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lssp_pkg::cell_ctl_t              ctl,
  input  logic signed [lssp_pkg::KEY_W-1:0] key,
  input  logic signed [lssp_pkg::SUM_W-1:0] sum,
  input  logic                             prev_valid,
  input  logic signed [lssp_pkg::SUM_W-1:0] prev_prefix,
  input  logic [IDX_W-1:0]                 prev_idx,
  output logic                             valid,
  output logic signed [lssp_pkg::SUM_W-1:0] prefix,
  output logic [IDX_W-1:0]                 idx,
  output logic                             hit_key,
  output logic [IDX_W-1:0]                 hit_idx,
  output logic                             hit_sum
);

  logic signed [lssp_pkg::KEY_W-1:0] prefix_ext;
  logic                              key_eq;
  logic                              sum_eq;

  assign prefix_ext = lssp_pkg::KEY_W'(prefix);
  assign key_eq     = valid && (prefix_ext == key);
  assign sum_eq     = valid && (prefix == sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      prefix <= prev_prefix;
      idx    <= prev_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_key <= 1'b0;
      hit_sum <= 1'b0;
      hit_idx <= '0;
    end else if (ctl.cmp_en) begin
      hit_key <= key_eq;
      hit_sum <= sum_eq;
      hit_idx <= key_eq ? idx : '0;
    end
  end

endmodule

// ===== rtl/core/lssp_chain.sv =====
// Row of table cells with the new entry shifted in at the head and hit merging.
`timescale 1ns / 1ps

module lssp_chain #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lssp_pkg::cell_ctl_t               ctl,
  input  logic signed [lssp_pkg::KEY_W-1:0] key,
  input  logic signed [lssp_pkg::SUM_W-1:0] sum,
  input  logic signed [lssp_pkg::SUM_W-1:0] ins_prefix,
  input  logic [IDX_W-1:0]                  ins_idx,
  output logic                              key_hit,
  output logic [IDX_W-1:0]                  key_idx,
  output logic                              sum_hit
);

  logic [DEPTH-1:0]                      valid;
  logic signed [lssp_pkg::SUM_W-1:0]     prefix [DEPTH];
  logic [IDX_W-1:0]                      idx    [DEPTH];
  logic [DEPTH-1:0]                      hit_key;
  logic [DEPTH-1:0]                      hit_sum;
  logic [IDX_W-1:0]                      hit_idx [DEPTH];

  for (genvar c = 0; c < DEPTH; c++) begin : g_cell
    if (c == 0) begin : g_head
      lssp_cell #(.IDX_W(IDX_W)) u_cell (
        .clk, .rst, .ctl, .key, .sum,
        .prev_valid (1'b1),
        .prev_prefix(ins_prefix),
        .prev_idx   (ins_idx),
        .valid      (valid[c]),
        .prefix     (prefix[c]),
        .idx        (idx[c]),
        .hit_key    (hit_key[c]),
        .hit_idx    (hit_idx[c]),
        .hit_sum    (hit_sum[c])
      );
    end else begin : g_body
      lssp_cell #(.IDX_W(IDX_W)) u_cell (
        .clk, .rst, .ctl, .key, .sum,
        .prev_valid (valid[c-1]),
        .prev_prefix(prefix[c-1]),
        .prev_idx   (idx[c-1]),
        .valid      (valid[c]),
        .prefix     (prefix[c]),
        .idx        (idx[c]),
        .hit_key    (hit_key[c]),
        .hit_idx    (hit_idx[c]),
        .hit_sum    (hit_sum[c])
      );
    end
  end

  always_comb begin
    key_idx = '0;
    for (int c = 0; c < DEPTH; c++) begin
      key_idx = key_idx | hit_idx[c];
    end
  end

  assign key_hit = |hit_key;
  assign sum_hit = |hit_sum;

  a_key_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_key))
    else $error("more than one cell matched the lookup key");
  a_sum_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_sum))
    else $error("more than one cell holds the running sum");

endmodule

// ===== rtl/core/longest_subarray_sum_prefix_table.sv =====
// Top level: longest subarray with a given sum over a prefix-sum table of cells.
`timescale 1ns / 1ps

// Usage:
//   Request channel: start with req (value, last), taken when start is high and
//   busy is low. busy is raised in the cycle after a request is taken and then falls.
//   Result channel: done pulses for one cycle with res (best_length, last_res,
//   overflow); the receiver takes it in that cycle and cannot stall it.
//   Configuration: cfg_we with cfg_wdata writes target_sum; write while idle.
// Timing:
//   The request cycle computes the running sum and lookup key and every cell
//   compares its stored prefix against both in parallel. The next cycle merges
//   the cell hits, updates the best length and shifts a new prefix into the head
//   of the cell row. done follows in the cycle after that. A new request is held
//   off while busy is high, until the compare-then-update pass over the row ends.
// Reset:
//   rst clears target_sum, the running state and every cell's valid bit.
//   A request marked last clears the same state, except target_sum, once its
//   result is formed. Requests beyond MAX_ELEMENTS only raise overflow.
module longest_subarray_sum_prefix_table #(
  parameter int MAX_ELEMENTS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  lssp_pkg::req_t                     req,
  output logic                               busy,
  input  logic                               cfg_we,
  input  logic signed [lssp_pkg::TARGET_W-1:0] cfg_wdata,
  output logic                               done,
  output lssp_pkg::res_t                     res
);

  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic signed [lssp_pkg::TARGET_W-1:0] target;
  logic signed [lssp_pkg::SUM_W-1:0]    running_sum;
  logic [CNT_W-1:0]                     count;
  logic [CNT_W-1:0]                     best;
  logic                                 overflowed;

  logic signed [lssp_pkg::SUM_W-1:0]    sum_q;
  logic                                 key_zero;
  logic                                 last_q;
  logic                                 in_range;

  logic                                 accept;
  logic signed [lssp_pkg::SUM_W-1:0]    sum_now;
  logic signed [lssp_pkg::KEY_W-1:0]    key_now;
  lssp_pkg::cell_ctl_t                  cell_ctl;
  logic                                 key_hit;
  logic [IDX_W-1:0]                     key_idx;
  logic                                 sum_hit;

  logic [CNT_W-1:0]                     cand;
  logic [CNT_W-1:0]                     best_next;
  logic                                 ovf_next;
  logic                                 insert;
  logic [lssp_pkg::BEST_W+CNT_W-1:0]    best_ext;

  assign accept  = start && !busy;
  assign sum_now = running_sum + lssp_pkg::SUM_W'(req.value);
  assign key_now = lssp_pkg::KEY_W'(sum_now) - lssp_pkg::KEY_W'(target);

  always_comb begin
    priority if (key_zero) begin
      cand = count + CNT_W'(1);
    end else if (key_hit) begin
      cand = count - CNT_W'(key_idx);
    end else begin
      cand = '0;
    end
  end

  assign best_next = (in_range && (cand > best)) ? cand : best;
  assign ovf_next  = overflowed || !in_range;
  assign insert    = busy && in_range && (sum_q != '0) && !sum_hit;

  assign cell_ctl.cmp_en = accept;
  assign cell_ctl.shift  = insert;
  assign cell_ctl.clear  = busy && last_q;

  lssp_chain #(.DEPTH(MAX_ELEMENTS), .IDX_W(IDX_W)) u_chain (
    .clk, .rst,
    .ctl       (cell_ctl),
    .key       (key_now),
    .sum       (sum_now),
    .ins_prefix(sum_q),
    .ins_idx   (count[IDX_W-1:0]),
    .key_hit,
    .key_idx,
    .sum_hit
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_we) begin
      target <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_q    <= sum_now;
      key_zero <= (key_now == '0);
      last_q   <= req.last;
      in_range <= (count < CNT_W'(MAX_ELEMENTS));
    end
  end

  assign best_ext = {{lssp_pkg::BEST_W{1'b0}}, best_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      running_sum <= '0;
      count       <= '0;
      best        <= '0;
      overflowed  <= 1'b0;
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) begin
        if (last_q) begin
          running_sum <= '0;
          count       <= '0;
          best        <= '0;
          overflowed  <= 1'b0;
        end else begin
          best       <= best_next;
          overflowed <= ovf_next;
          if (in_range) begin
            running_sum <= sum_q;
            count       <= count + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      res.best_length <= best_ext[lssp_pkg::BEST_W-1:0];
      res.last_res    <= last_q;
      res.overflow    <= ovf_next;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a request in flight");
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("busy held longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted request did not raise busy");

endmodule
